>>> rtl/core/pwd_pkg.sv
// Shared types and constants for the protobuf wire primitive decoder.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package pwd_pkg;

	// decode modes
	localparam logic [2:0] MODE_TAG  = 3'd0;
	localparam logic [2:0] MODE_LEN  = 3'd1;
	localparam logic [2:0] MODE_BOOL = 3'd2;
	localparam logic [2:0] MODE_U32  = 3'd3;
	localparam logic [2:0] MODE_U64  = 3'd4;
	localparam logic [2:0] MODE_F64  = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EARLY = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// byte classification from the front end
	localparam logic [1:0] KIND_MORE  = 2'd0; // value continues
	localparam logic [1:0] KIND_FINAL = 2'd1; // last byte of a value
	localparam logic [1:0] KIND_EARLY = 2'd2; // buffer ended mid-value
	localparam logic [1:0] KIND_LONG  = 2'd3; // varint past ten bytes

	localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;
	localparam logic [3:0] FIXED_BYTES      = 4'd8;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [2:0]  mode;
		logic [31:0] bytes_left;
	} in_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [28:0] field_number;
		logic [2:0]  wire_type;
		logic [3:0]  bytes_used;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] bytes_left;
		logic [3:0]  index;
		logic [2:0]  mode;
		logic [1:0]  kind;
	} q_entry_t;

endpackage

>>> rtl/core/protobuf_wire_primitive_decoder_core.sv
// Protobuf wire primitive decoder: one encoded byte per input word, one
// decoded value per output word. Uses pwd_pkg, pwd_front, pwd_queue, pwd_back.
`timescale 1ns / 1ps

// Feed the encoded buffer one byte per word together with the decode mode
// (tag, length, bool, uint32, uint64, fixed64; sampled on a value's first
// byte) and the count of buffer bytes left after this byte. The core takes
// one byte every clock cycle for as long as results are drained; a value's
// result word is presented once its last byte has passed through the queue
// and the back end has loaded the output register from the queue head.
// Bytes that do not end a value produce no output word. Errors (buffer
// ended early, varint past ten bytes, tag/uint32 wider than 32 bits, length
// beyond the remaining bytes) end the value with a status and a zero value.
// The rate is set by the single 64-bit accumulator update in the back end;
// a stalled output lets the two-entry queue absorb bytes before item_ready
// drops.

module protobuf_wire_primitive_decoder_core import pwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;
	q_entry_t push_entry;
	q_entry_t head;

	// position tracking and byte classification
	pwd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// decouples input handshake from output stalls
	pwd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	// accumulation, range checks, output register
	pwd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> rtl/core/pwd_front.sv
// Front end: accepts input words, tracks byte position and latched mode,
// and classifies each byte. Depends on pwd_pkg.
`timescale 1ns / 1ps

module pwd_front import pwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      push,
	output q_entry_t  push_entry,
	input  logic      q_full
);

	logic [3:0] count_q;
	logic [2:0] mode_q;
	logic [2:0] eff_mode;
	logic [3:0] used;
	logic [1:0] kind;

	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;
	assign eff_mode   = (count_q == 4'd0) ? item.mode : mode_q;
	assign used       = count_q + 4'd1;

	always_comb begin
		if (eff_mode == MODE_F64) begin
			if (used >= FIXED_BYTES)
				kind = KIND_FINAL;
			else if (item.bytes_left == 32'd0)
				kind = KIND_EARLY;
			else
				kind = KIND_MORE;
		end else if (item.data_byte[7]) begin
			if (used >= MAX_VARINT_BYTES)
				kind = KIND_LONG;
			else if (item.bytes_left == 32'd0)
				kind = KIND_EARLY;
			else
				kind = KIND_MORE;
		end else begin
			kind = KIND_FINAL;
		end
	end

	always_comb begin
		push_entry.data_byte  = item.data_byte;
		push_entry.bytes_left = item.bytes_left;
		push_entry.index      = count_q;
		push_entry.mode       = eff_mode;
		push_entry.kind       = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			mode_q  <= MODE_TAG;
		end else if (push) begin
			count_q <= (kind == KIND_MORE) ? used : 4'd0;
			mode_q  <= eff_mode;
		end
	end

endmodule

>>> rtl/core/pwd_queue.sv
// Two-entry queue between front and back ends.
// Depends on pwd_pkg.
`timescale 1ns / 1ps

module pwd_queue import pwd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     q_valid,
	output q_entry_t head
);

	q_entry_t   mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/pwd_back.sv
// Back end: accumulates varint groups or fixed64 bytes, checks range and
// holds the result in an output register. Depends on pwd_pkg.
`timescale 1ns / 1ps

module pwd_back import pwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  q_entry_t  head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic [63:0] acc_q;
	logic        out_valid_q;
	out_item_t   result_q;
	logic [63:0] base;
	logic [63:0] grp;
	logic [63:0] acc_new;
	logic [5:0]  shamt;
	logic        emits;
	out_item_t   res;

	assign base  = (head.index == 4'd0) ? 64'd0 : acc_q;
	// 7 * index for varints (index <= 9), 8 * index for fixed64 (index <= 7)
	assign shamt = (head.mode == MODE_F64) ? {head.index[2:0], 3'b000}
		: 6'(({2'b00, head.index} << 3) - {2'b00, head.index});
	assign grp   = (head.mode == MODE_F64) ? ({56'd0, head.data_byte} << shamt)
		: ({57'd0, head.data_byte[6:0]} << shamt);
	assign acc_new = base | grp;

	assign emits = (head.kind != KIND_MORE);
	assign pop   = q_valid && (!emits || !out_valid_q || result_ready);

	always_comb begin
		res            = '0;
		res.bytes_used = head.index + 4'd1;
		case (head.kind)
			KIND_EARLY: res.status = ST_EARLY;
			KIND_LONG:  res.status = ST_LONG;
			KIND_FINAL: begin
				case (head.mode)
					MODE_TAG: begin
						if (|acc_new[63:32]) begin
							res.status = ST_RANGE;
						end else begin
							res.value        = acc_new;
							res.field_number = acc_new[31:3];
							res.wire_type    = acc_new[2:0];
						end
					end
					MODE_LEN: begin
						if (acc_new > {32'd0, head.bytes_left})
							res.status = ST_RANGE;
						else
							res.value = acc_new;
					end
					MODE_BOOL: res.value = {63'd0, (acc_new != 64'd0)};
					MODE_U32: begin
						if (|acc_new[63:32])
							res.status = ST_RANGE;
						else
							res.value = acc_new;
					end
					default: res.value = acc_new;
				endcase
			end
			default: res.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			acc_q <= acc_new;
		if (pop && emits)
			result_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && emits)
			out_valid_q <= 1'b1;
		else if (result_ready)
			out_valid_q <= 1'b0;
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

>>> verif/tb.sv
// Self-checking testbench for protobuf_wire_primitive_decoder_core.
// Uses pwd_pkg for the word types and the mode and status codes; needs only the RTL.
`timescale 1ns / 1ps

module tb;
	import pwd_pkg::*;

	localparam int RAND_WORDS = 1850;   // random input words after the directed part
	localparam int CYCLE_LIMIT = 400000; // many times the slowest legal run
	localparam int BURST_LO = 900;      // words sent in this range: no random idling on either side
	localparam int BURST_HI = 1300;
	localparam int TAIL_CYCLES = 20;    // wait after the last expected result for any stray output

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;

	protobuf_wire_primitive_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// input words waiting to be sent, and decoded values waiting to come out
	in_item_t byte_q[$];
	out_item_t decoded_q[$];
	logic [7:0] vbytes[$];   // scratch: bytes of the value being built

	int bytes_sent = 0;
	int drain_at = -1;       // word index where the sender waits for all results
	int mismatches = 0;
	int cycles = 0;
	logic item_fire = 1'b0;
	logic burst;

	// decoder state mirror
	logic [63:0] acc = '0;
	logic [3:0] acc_cnt = '0;
	logic [2:0] acc_mode = '0;
	out_item_t want;

	assign burst = (bytes_sent >= BURST_LO) && (bytes_sent < BURST_HI);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fold one accepted byte into the running value; on completion or error
	// push the decoded word that the block must return.
	task automatic decode_byte(input in_item_t w);
		out_item_t r;
		logic [3:0] used;
		bit done;
		r = '0;
		done = 1'b0;
		if (acc_cnt == 0) begin
			acc_mode = w.mode;  // mode only counts on a value's first byte
			acc = '0;
		end
		used = acc_cnt + 4'd1;
		r.bytes_used = used;
		if (acc_mode == MODE_F64) begin
			// raw little-endian bytes, always eight of them unless the buffer ends
			acc = acc | ({56'd0, w.data_byte} << (8 * acc_cnt));
			if (used >= FIXED_BYTES) begin
				r.value = acc;
				done = 1'b1;
			end else if (w.bytes_left == 0) begin
				r.status = ST_EARLY;
				done = 1'b1;
			end
		end else begin
			// 7-bit groups; on the tenth byte everything above bit 63 drops off
			acc = acc | ({57'd0, w.data_byte[6:0]} << (7 * acc_cnt));
			if (w.data_byte[7]) begin
				// a continuation on byte ten is too long, even at buffer end
				if (used >= MAX_VARINT_BYTES) begin
					r.status = ST_LONG;
					done = 1'b1;
				end else if (w.bytes_left == 0) begin
					r.status = ST_EARLY;
					done = 1'b1;
				end
			end else begin
				done = 1'b1;
				case (acc_mode)
					MODE_TAG: begin
						if (acc[63:32] != 0) begin
							r.status = ST_RANGE;
						end else begin
							r.value = acc;
							r.field_number = acc[31:3];
							r.wire_type = acc[2:0];
						end
					end
					MODE_LEN: begin
						// length may not run past the rest of the buffer
						if (acc > {32'd0, w.bytes_left}) r.status = ST_RANGE;
						else r.value = acc;
					end
					MODE_BOOL: r.value = {63'd0, acc != 0};
					MODE_U32: begin
						if (acc[63:32] != 0) r.status = ST_RANGE;
						else r.value = acc;
					end
					default: r.value = acc;  // uint64, and the unused codes 6 and 7
				endcase
			end
		end
		if (done) begin
			decoded_q.push_back(r);
			acc_cnt = '0;
			acc = '0;
		end else begin
			acc_cnt = used;
		end
	endtask

	task automatic cmp_field(input string fname, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, got_v);
		end
	endtask

	// Canonical varint of v, optionally padded with redundant zero groups
	// (never past ten bytes).
	task automatic enc_varint(input logic [63:0] v, input int pad);
		logic [63:0] rem;
		logic [7:0] last;
		rem = v;
		vbytes.delete();
		do begin
			vbytes.push_back({1'b1, rem[6:0]});
			rem = rem >> 7;
		end while (rem != 0);
		for (int k = 0; k < pad && vbytes.size() < 10; k++) vbytes.push_back(8'h80);
		last = vbytes.pop_back();
		vbytes.push_back({1'b0, last[6:0]});
	endtask

	// Queue the bytes in vbytes as one value; left_last is bytes_left on the
	// final byte. With noisy set, later bytes carry random modes.
	task automatic queue_value(input logic [2:0] m, input logic [31:0] left_last,
			input bit noisy);
		in_item_t w;
		for (int k = 0; k < vbytes.size(); k++) begin
			w.data_byte = vbytes[k];
			w.mode = (k == 0 || !noisy) ? m : 3'($urandom_range(0, 7));
			w.bytes_left = left_last + 32'(vbytes.size() - 1 - k);
			byte_q.push_back(w);
		end
	endtask

	function automatic logic [2:0] pick_mode();
		if ($urandom_range(99) < 4) return 3'($urandom_range(6, 7));
		return 3'($urandom_range(0, 5));
	endfunction

	// Sender: a new word goes out at the falling edge after the last one was taken.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_fire)) begin
			if (byte_q.size() != 0 && !(bytes_sent == drain_at && decoded_q.size() != 0)
					&& (burst || $urandom_range(99) >= 32)) begin
				item_valid <= 1'b1;
				item <= byte_q.pop_front();
				bytes_sent <= bytes_sent + 1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) result_ready <= burst || ($urandom_range(99) >= 32);

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		item_fire <= arst_n && item_valid && item_ready;
		if (arst_n) begin
			if (item_valid && item_ready) decode_byte(item);
			if (result_valid && result_ready) begin
				if (decoded_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %h", $time, result);
				end else begin
					want = decoded_q.pop_front();
					cmp_field("value", want.value, result.value);
					cmp_field("field_number", 64'(want.field_number), 64'(result.field_number));
					cmp_field("wire_type", 64'(want.wire_type), 64'(result.wire_type));
					cmp_field("bytes_used", 64'(want.bytes_used), 64'(result.bytes_used));
					cmp_field("status", 64'(want.status), 64'(result.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("protobuf_wire_primitive_decoder_core regression: fail");
			$finish;
		end
	end

	initial begin
		logic [63:0] v;
		logic [31:0] left;
		logic [2:0] m;
		int pick, cut, pad, n_dir;

		// ---- directed values ----
		enc_varint(64'h08, 0);                 // field 1, varint wire type
		queue_value(MODE_TAG, 32'd7, 1'b0);
		enc_varint(64'hFFFF_FFFF, 0);          // widest legal tag, largest bytes_left
		queue_value(MODE_TAG, 32'hFFFF_FFFF, 1'b0);
		enc_varint(64'h1_0000_0000, 0);        // tag wider than 32 bits
		queue_value(MODE_TAG, 32'd0, 1'b0);
		enc_varint(64'h1_0000_0000, 0);        // uint32 out of range
		queue_value(MODE_U32, 32'd3, 1'b0);
		enc_varint(64'hFFFF_FFFF, 0);
		queue_value(MODE_U32, 32'd0, 1'b0);
		enc_varint(64'd5, 0);                  // length exactly fits
		queue_value(MODE_LEN, 32'd5, 1'b0);
		enc_varint(64'd6, 0);                  // length one past the buffer
		queue_value(MODE_LEN, 32'd5, 1'b0);
		enc_varint(64'hFFFF_FFFF, 0);
		queue_value(MODE_LEN, 32'hFFFF_FFFF, 1'b0);
		enc_varint(64'd128, 0);                // bool from a two-byte nonzero
		queue_value(MODE_BOOL, 32'd9, 1'b0);
		enc_varint(64'd0, 2);                  // padded zero bool
		queue_value(MODE_BOOL, 32'd1, 1'b0);
		enc_varint(64'hFFFF_FFFF_FFFF_FFFF, 0); // ten bytes, last one 0x01
		queue_value(MODE_U64, 32'd0, 1'b0);
		enc_varint(64'h8000_0000_0000_0000, 0); // tenth byte with high bits that fall off
		vbytes[9] = 8'h7F;
		queue_value(MODE_U64, 32'd4, 1'b0);
		vbytes.delete();                       // fixed64 all ones
		repeat (8) vbytes.push_back(8'hFF);
		queue_value(MODE_F64, 32'd0, 1'b0);
		vbytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
		queue_value(MODE_F64, 32'd2, 1'b1);    // byte order, mode wobbling mid-value
		vbytes.delete();                       // too long, and the buffer ends there too
		repeat (10) vbytes.push_back(8'hFF);
		queue_value(MODE_U64, 32'd0, 1'b0);
		vbytes = '{8'h80};                     // varint cut by buffer end
		queue_value(MODE_U32, 32'd0, 1'b0);
		vbytes = '{8'hAA, 8'h55, 8'h00};       // fixed64 cut by buffer end
		queue_value(MODE_F64, 32'd0, 1'b0);
		enc_varint(64'd300, 0);                // unused mode codes act as uint64
		queue_value(3'd6, 32'd11, 1'b0);
		enc_varint(64'd300, 0);
		queue_value(3'd7, 32'd11, 1'b0);
		enc_varint(64'h1234_5678, 0);          // tag with later bytes in other modes
		queue_value(MODE_TAG, 32'd20, 1'b1);
		n_dir = byte_q.size();

		// ---- random values ----
		while (byte_q.size() < n_dir + RAND_WORDS) begin
			if (drain_at < 0 && byte_q.size() >= n_dir + RAND_WORDS / 2)
				drain_at = byte_q.size();
			pick = $urandom_range(99);
			m = pick_mode();
			if (pick < 70) begin
				// well-formed value with random content
				v = '0;
				if (m == MODE_F64) begin
					vbytes.delete();
					repeat (8) vbytes.push_back(8'($urandom));
				end else begin
					v = {$urandom, $urandom} >> $urandom_range(0, 63);
					if ((m == MODE_TAG || m == MODE_U32) && $urandom_range(99) < 85)
						v = {32'd0, v[31:0]};
					if (m == MODE_LEN && $urandom_range(99) < 80) v = $urandom_range(0, 400);
					if (m == MODE_BOOL && $urandom_range(1)) v = $urandom_range(0, 1);
					pad = ($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0;
					enc_varint(v, pad);
					if (vbytes.size() == 10 && $urandom_range(1))
						vbytes[9] = {1'b0, 7'($urandom)};
				end
				cut = $urandom_range(0, 3);
				if (m == MODE_LEN) begin
					case (cut)
						0: left = v[31:0];
						1: left = v[31:0] + $urandom_range(1, 50);
						2: left = v[31:0] - 1;
						default: left = $urandom;
					endcase
				end else begin
					left = (cut == 0) ? 32'd0 : (cut == 3) ? $urandom : $urandom_range(0, 500);
				end
				queue_value(m, left, $urandom_range(99) < 15);
			end else if (pick < 82) begin
				// buffer ends inside the value
				if (m == MODE_F64) begin
					vbytes.delete();
					repeat (8) vbytes.push_back(8'($urandom));
				end else begin
					enc_varint(({$urandom, $urandom} >> $urandom_range(0, 56)) | 64'h80, 0);
				end
				cut = $urandom_range(0, vbytes.size() - 2);
				while (vbytes.size() > cut + 1) void'(vbytes.pop_back());
				queue_value(m, 32'd0, $urandom_range(99) < 15);
			end else if (pick < 87) begin
				// continuation still set on the tenth byte
				if (m == MODE_F64) m = MODE_U64;
				vbytes.delete();
				repeat (10) vbytes.push_back({1'b1, 7'($urandom)});
				queue_value(m, $urandom_range(1) ? 32'd0 : $urandom, 1'b0);
			end else begin
				// stray bytes, any mode, often at the buffer end
				repeat ($urandom_range(1, 3)) begin
					vbytes = '{8'($urandom)};
					queue_value(3'($urandom_range(0, 7)),
						$urandom_range(1) ? 32'd0 : $urandom, 1'b0);
				end
			end
		end

		// ---- reset, then let the sender run ----
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// checked at the rising edge, where the sender's outputs are settled
		while (byte_q.size() != 0 || item_valid) @(posedge clk);
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("protobuf_wire_primitive_decoder_core regression: pass");
		end else begin
			$display("protobuf_wire_primitive_decoder_core regression: fail");
		end
		$finish;
	end

endmodule
